@@ rtl/dsha_pkg.sv @@
// Shared types, constants and round functions for the double SHA-256 unit.
package dsha_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned NumRounds  = 64;
   localparam int unsigned NumCfg     = 4;
   localparam int unsigned CfgIdxWidth = 2;
   localparam int unsigned CfgWidth   = 64;

   localparam logic [1:0] CSR_MID_0_1 = 2'd0;
   localparam logic [1:0] CSR_MID_2_3 = 2'd1;
   localparam logic [1:0] CSR_MID_4_5 = 2'd2;
   localparam logic [1:0] CSR_MID_6_7 = 2'd3;

   localparam logic [31:0] PadBit   = 32'h8000_0000;
   localparam logic [31:0] Len640   = 32'd640;
   localparam logic [31:0] Len256   = 32'd256;

   typedef logic [31:0] word_type;
   typedef word_type [7:0]  chain_type;
   typedef word_type [15:0] sched_type;

   // Working state of one round cell plus the message window it carries.
   typedef struct packed {
      chain_type v;
      sched_type w;
      chain_type base;
   } stage_type;

   // Payload of one request: the last four header words.
   typedef struct packed {
      word_type tail_word_0;
      word_type tail_word_1;
      word_type tail_word_2;
      word_type tail_word_3;
   } req_type;

   // Payload of one response: the eight digest words.
   typedef struct packed {
      word_type hash_word_0;
      word_type hash_word_1;
      word_type hash_word_2;
      word_type hash_word_3;
      word_type hash_word_4;
      word_type hash_word_5;
      word_type hash_word_6;
      word_type hash_word_7;
   } rsp_type;

   // Payload of one register write.
   typedef struct packed {
      logic [CfgIdxWidth-1:0] idx;
      logic [CfgWidth-1:0]    value;
   } csr_type;

   localparam word_type [63:0] RoundK = {
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B,
      32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01,
      32'h243185BE, 32'h550C7DC3, 32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7,
      32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA, 32'h983E5152,
      32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC,
      32'h53380D13, 32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3, 32'hD192E819,
      32'hD6990624, 32'hF40E3585, 32'h106AA070, 32'h19A4C116, 32'h1E376C08,
      32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F,
      32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

   localparam chain_type InitHash = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      round_k = RoundK[6'd63 - idx];
   endfunction

endpackage

@@ rtl/dsha_if.sv @@
// Valid/ready stream interface carrying a generic payload.
interface dsha_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/double_sha256_from_midstate_unit.sv @@
// Top level: midstate registers, two chained compressions, output stage.
//
// Usage: write the 256-bit midstate through the csr_ channel (four 64-bit
// registers, index 0..3; other indexes are ignored) while the unit is idle.
// Each req_ request carries the last four header words; one rsp_ request
// returns the eight words of the double SHA-256 digest.
// Pipeline: 64 registered round cells per compression, two compressions in
// series, then the output register. Throughput: one request per cycle
// while the chain advances, set by the single round cell that each pipeline
// stage holds.
// The whole cell chain advances only when the output register is empty or
// being drained; if rsp_ready stays low on a pending response, the chain
// freezes and req_ready falls, so no result is lost or reordered.
// Reset clears the midstate to zero and every stage valid bit.
module double_sha256_from_midstate_unit (
   input logic clock,
   input logic reset,
   dsha_if.sink   req,
   dsha_if.source rsp,
   dsha_if.sink   csr
);
   localparam int unsigned Depth = 2 * dsha_pkg::NumRounds;

   logic [dsha_pkg::CfgWidth-1:0] mid_ff [dsha_pkg::NumCfg];
   logic [Depth-1:0]  vld_ff, vld_in;
   logic              out_vld_ff, advance;
   dsha_pkg::chain_type mid, dig1, dig2, out_ff;
   dsha_pkg::stage_type s1_in, s2_in;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dsha_pkg::NumCfg; i++) mid_ff[i] <= '0;
      end else if (csr.valid) begin
         unique case (csr.data.idx)
            dsha_pkg::CSR_MID_0_1: mid_ff[0] <= csr.data.value;
            dsha_pkg::CSR_MID_2_3: mid_ff[1] <= csr.data.value;
            dsha_pkg::CSR_MID_4_5: mid_ff[2] <= csr.data.value;
            dsha_pkg::CSR_MID_6_7: mid_ff[3] <= csr.data.value;
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < dsha_pkg::NumCfg; i++) begin : g_mid
      assign mid[2*i]   = mid_ff[i][63:32];
      assign mid[2*i+1] = mid_ff[i][31:0];
   end

   assign advance   = !out_vld_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      s1_in.v    = mid;
      s1_in.base = mid;
      s1_in.w    = '0;
      s1_in.w[0] = req.data.tail_word_0;
      s1_in.w[1] = req.data.tail_word_1;
      s1_in.w[2] = req.data.tail_word_2;
      s1_in.w[3] = req.data.tail_word_3;
      s1_in.w[4] = dsha_pkg::PadBit;
      s1_in.w[15] = dsha_pkg::Len640;
      s2_in.v    = dsha_pkg::InitHash;
      s2_in.base = dsha_pkg::InitHash;
      s2_in.w    = '0;
      s2_in.w[7:0] = dig1;
      s2_in.w[8]   = dsha_pkg::PadBit;
      s2_in.w[15]  = dsha_pkg::Len256;
   end

   dsha_compress u_first  (.clock(clock), .advance(advance), .stage_in(s1_in), .digest(dig1));
   dsha_compress u_second (.clock(clock), .advance(advance), .stage_in(s2_in), .digest(dig2));

   assign vld_in = {vld_ff[Depth-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= dig2;
      end
   end

   assign rsp.valid            = out_vld_ff;
   assign rsp.data.hash_word_0 = out_ff[0];
   assign rsp.data.hash_word_1 = out_ff[1];
   assign rsp.data.hash_word_2 = out_ff[2];
   assign rsp.data.hash_word_3 = out_ff[3];
   assign rsp.data.hash_word_4 = out_ff[4];
   assign rsp.data.hash_word_5 = out_ff[5];
   assign rsp.data.hash_word_6 = out_ff[6];
   assign rsp.data.hash_word_7 = out_ff[7];
endmodule

@@ rtl/dsha_round_cell.sv @@
// One SHA-256 round with its message schedule step, registered.
module dsha_round_cell #(
   parameter logic [5:0] Round = 6'd0
) (
   input  logic                clock,
   input  logic                advance,
   input  dsha_pkg::stage_type stage_in,
   output dsha_pkg::stage_type stage_out
);
   dsha_pkg::stage_type stage_ff, stage_in_w;
   dsha_pkg::word_type  e, a, big1, big0, ch, maj, t1, t2, s0, s1, wt, wn;
   dsha_pkg::chain_type v;

   always_comb begin
      v    = stage_in.v;
      e    = v[4];
      a    = v[0];
      wt   = stage_in.w[0];
      big1 = dsha_pkg::rotr(e, 6) ^ dsha_pkg::rotr(e, 11) ^ dsha_pkg::rotr(e, 25);
      ch   = v[6] ^ (e & (v[5] ^ v[6]));
      t1   = v[7] + big1 + ch + dsha_pkg::round_k(Round) + wt;
      big0 = dsha_pkg::rotr(a, 2) ^ dsha_pkg::rotr(a, 13) ^ dsha_pkg::rotr(a, 22);
      maj  = (a & v[1]) | (v[2] & (a | v[1]));
      t2   = big0 + maj;
      s0   = dsha_pkg::rotr(stage_in.w[1], 7) ^ dsha_pkg::rotr(stage_in.w[1], 18)
             ^ (stage_in.w[1] >> 3);
      s1   = dsha_pkg::rotr(stage_in.w[14], 17) ^ dsha_pkg::rotr(stage_in.w[14], 19)
             ^ (stage_in.w[14] >> 10);
      wn   = s1 + stage_in.w[9] + s0 + stage_in.w[0];
      stage_in_w.base = stage_in.base;
      stage_in_w.v    = {v[6:4], v[3] + t1, v[2:0], t1 + t2};
      // slide the schedule window by one word
      stage_in_w.w    = {wn, stage_in.w[15:1]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;
endmodule

@@ rtl/dsha_compress.sv @@
// Chain of 64 round cells forming one SHA-256 compression, with final add.
module dsha_compress (
   input  logic                clock,
   input  logic                advance,
   input  dsha_pkg::stage_type stage_in,
   output dsha_pkg::chain_type digest
);
   dsha_pkg::stage_type link [dsha_pkg::NumRounds+1];

   assign link[0] = stage_in;

   for (genvar r = 0; r < dsha_pkg::NumRounds; r++) begin : g_round
      dsha_round_cell #(.Round(6'(r))) u_cell (
         .clock    (clock),
         .advance  (advance),
         .stage_in (link[r]),
         .stage_out(link[r+1])
      );
   end

   for (genvar i = 0; i < 8; i++) begin : g_add
      assign digest[i] = link[dsha_pkg::NumRounds].base[i]
                         + link[dsha_pkg::NumRounds].v[i];
   end
endmodule

@@ rtl/dsha_checker.sv @@
// Port-level checks for the double SHA-256 unit, bound to the top level.
module dsha_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);
   // a stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("req_ready during stall");
   // a pending response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("response after reset");
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("csr not ready");
endmodule

bind double_sha256_from_midstate_unit dsha_checker u_dsha_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .csr_ready(csr.ready)
);
